// File: rtl/core/lsbse_pkg.sv
// Shared types and constants for the LSB steganography extractor core.
// No dependencies.
package lsbse_pkg;

    localparam int FIELD_BITS_DEF = 32;
    localparam int MAGIC_BITS     = 48;
    localparam int CFG_BITS       = 32;
    localparam int CHAR_BITS      = 8;
    localparam int HDR_CNT_BITS   = 6;

    // "secret", first character in the low byte
    localparam logic [MAGIC_BITS-1:0] MAGIC_WORD = 48'h7465_7263_6573;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_METHOD  = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        KIND_CHAR      = 3'd0,
        KIND_NOMARK    = 3'd1,
        KIND_BADMETHOD = 3'd2,
        KIND_BADLEN    = 3'd3,
        KIND_EMPTY     = 3'd4
    } kind_t;

endpackage

// File: rtl/core/lsb_stego_extractor_core.sv
// LSB steganography extractor: parses mark, method, length and payload from pixel LSBs.
// Depends on lsbse_pkg.
// A result goes to the m_* register as its pixel is accepted, or to the skid while m_* is held.
// Throughput: one pixel per cycle while the skid is empty; a two-deep output stage (register
// plus skid) lets pixels keep flowing while one result waits on m_tready.
// Reset (aresetn low, synchronous): parse returns to the mark phase, output stage empties,
// accepted_method clears to zero.
module lsb_stego_extractor_core #(
    parameter int FIELD_BITS = lsbse_pkg::FIELD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lsbse_pkg::CFG_BITS-1:0] cfg_wr_data,   // accepted_method
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,       // [7:0] red_value, [15:8] green_value
    input  logic                           s_tuser,       // start_of_image
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,       // [7:0] char_value
    output logic [2:0]                     m_tuser,       // [2:0] kind
    output logic                           m_tlast        // last
);
    import lsbse_pkg::*;

    logic [CFG_BITS-1:0]     method_reg;
    phase_t                  phase_reg, phase_next;
    logic [HDR_CNT_BITS-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [MAGIC_BITS-1:0]   magic_reg, magic_next;
    logic [FIELD_BITS-1:0]   word_reg, word_next;
    logic [FIELD_BITS-1:0]   len_reg, len_next;
    logic [FIELD_BITS-1:0]   pay_cnt_reg, pay_cnt_next;
    logic [CHAR_BITS-1:0]    char_reg, char_next;

    logic                    out_valid_reg, skid_valid_reg;
    kind_t                   out_kind_reg, skid_kind_reg;
    logic [CHAR_BITS-1:0]    out_char_reg, skid_char_reg;
    logic                    out_last_reg, skid_last_reg;

    logic                    s_acc;
    logic                    rbit, gbit;
    phase_t                  phase_cur;
    logic [HDR_CNT_BITS-1:0] hdr_cnt_cur;
    logic                    res_valid;
    kind_t                   res_kind;
    logic [CHAR_BITS-1:0]    res_char;
    logic                    res_last;
    logic                    pop;

    assign s_tready = ~skid_valid_reg;
    assign s_acc    = s_tvalid & s_tready;
    assign rbit     = s_tdata[0];
    assign gbit     = s_tdata[8];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        // start of image restarts the parse on this very pixel
        phase_cur   = s_tuser ? PH_MAGIC : phase_reg;
        hdr_cnt_cur = s_tuser ? '0 : hdr_cnt_reg;

        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        magic_next   = magic_reg;
        word_next    = word_reg;
        len_next     = len_reg;
        pay_cnt_next = pay_cnt_reg;
        char_next    = char_reg;
        res_valid    = 1'b0;
        res_kind     = KIND_CHAR;
        res_char     = '0;
        res_last     = 1'b0;

        if (s_acc) begin
            phase_next   = phase_cur;
            hdr_cnt_next = hdr_cnt_cur;
            case (phase_cur)
                PH_MAGIC: begin
                    // shift in at the top: first bit ends up in bit 0
                    magic_next = {rbit, magic_reg[MAGIC_BITS-1:1]};
                    if (hdr_cnt_cur == HDR_CNT_BITS'(MAGIC_BITS - 1)) begin
                        hdr_cnt_next = '0;
                        if (magic_next != MAGIC_WORD) begin
                            phase_next = PH_DONE;
                            res_valid  = 1'b1;
                            res_kind   = KIND_NOMARK;
                            res_last   = 1'b1;
                        end else begin
                            phase_next = PH_METHOD;
                        end
                    end else begin
                        hdr_cnt_next = hdr_cnt_cur + 1'b1;
                    end
                end
                PH_METHOD: begin
                    word_next = {rbit, word_reg[FIELD_BITS-1:1]};
                    if (hdr_cnt_cur == HDR_CNT_BITS'(FIELD_BITS - 1)) begin
                        hdr_cnt_next = '0;
                        phase_next   = PH_LENGTH;
                    end else begin
                        hdr_cnt_next = hdr_cnt_cur + 1'b1;
                    end
                end
                PH_LENGTH: begin
                    len_next = {rbit, len_reg[FIELD_BITS-1:1]};
                    if (hdr_cnt_cur == HDR_CNT_BITS'(FIELD_BITS - 1)) begin
                        hdr_cnt_next = '0;
                        phase_next   = PH_DONE;
                        if (CFG_BITS'(word_reg) != method_reg) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_BADMETHOD;
                            res_last  = 1'b1;
                        end else if (len_next == '0) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_EMPTY;
                            res_last  = 1'b1;
                        end else if (len_next[2:0] != 3'd0) begin
                            res_valid = 1'b1;
                            res_kind  = KIND_BADLEN;
                            res_last  = 1'b1;
                        end else begin
                            phase_next   = PH_PAYLOAD;
                            pay_cnt_next = '0;
                        end
                    end else begin
                        hdr_cnt_next = hdr_cnt_cur + 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    char_next    = {gbit, char_reg[CHAR_BITS-1:1]};
                    pay_cnt_next = pay_cnt_reg + 1'b1;
                    if (pay_cnt_reg[2:0] == 3'd7) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_CHAR;
                        res_char  = char_next;
                        res_last  = (pay_cnt_next == len_reg);
                        if (res_last) begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                default: begin
                    // done: ignore pixels until the next start of image
                end
            endcase
        end
    end

    assign pop = out_valid_reg & m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg     <= '0;
            phase_reg      <= PH_MAGIC;
            hdr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                method_reg <= cfg_wr_data;
            end
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;

            if (!out_valid_reg || pop) begin
                if (skid_valid_reg) begin
                    // no request was taken this cycle, so the skid simply drains
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= res_valid;
                end
            end else if (res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        magic_reg   <= magic_next;
        word_reg    <= word_next;
        len_reg     <= len_next;
        pay_cnt_reg <= pay_cnt_next;
        char_reg    <= char_next;

        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_kind_reg <= skid_kind_reg;
                out_char_reg <= skid_char_reg;
                out_last_reg <= skid_last_reg;
            end else begin
                out_kind_reg <= res_kind;
                out_char_reg <= res_char;
                out_last_reg <= res_last;
            end
        end else if (res_valid) begin
            skid_kind_reg <= res_kind;
            skid_char_reg <= res_char;
            skid_last_reg <= res_last;
        end
    end

endmodule

// File: sim/lsb_stego_extractor_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for lsb_stego_extractor_core: drives pixel streams with hidden
// headers and payloads, predicts each report and character, checks them in order.
// Depends on lsbse_pkg and the core RTL.
module lsb_stego_extractor_core_test;
    import lsbse_pkg::*;

    localparam int FIELD     = FIELD_BITS_DEF;
    localparam int HDR_BITS  = MAGIC_BITS + 2 * FIELD;
    localparam int LIMIT     = 400000;
    localparam int HOLD_LEN  = 300;
    localparam int IDLE_PCT  = 17;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       last;
    } report_t;

    typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;

    class extract_scoreboard;
        logic [CFG_BITS-1:0]   method;
        phase_t                phase;
        int                    hdr_count;
        logic [MAGIC_BITS-1:0] mark_bits;
        logic [FIELD-1:0]      method_bits;
        logic [FIELD-1:0]      length_bits;
        logic [31:0]           bit_count;
        logic [7:0]            char_bits;
        report_t               awaited_reports[$];
        int                    failures;
        int                    chars_seen;
        int                    status_seen;

        function void restart();
            phase       = PH_MAGIC;
            hdr_count   = 0;
            mark_bits   = '0;
            method_bits = '0;
            length_bits = '0;
            bit_count   = '0;
            char_bits   = '0;
        endfunction

        function void clear();
            method = '0;
            restart();
        endfunction

        function void push(kind_t kind, logic [7:0] ch, logic last);
            report_t r;
            r.kind = kind;
            r.ch   = ch;
            r.last = last;
            awaited_reports = {awaited_reports, r};
        endfunction

        function int pending();
            return awaited_reports.size();
        endfunction

        // one accepted pixel; only the low bits of red and green matter
        function void note_pixel(logic sof, logic rb, logic gb);
            logic [2:0] pos;
            if (sof)
                restart();
            case (phase)
                PH_MAGIC: begin
                    mark_bits[hdr_count] = rb;
                    hdr_count++;
                    if (hdr_count == MAGIC_BITS) begin
                        hdr_count = 0;
                        if (mark_bits != MAGIC_WORD) begin
                            phase = PH_DONE;
                            push(KIND_NOMARK, 8'h00, 1'b1);
                        end else begin
                            phase = PH_METHOD;
                        end
                    end
                end
                PH_METHOD: begin
                    method_bits[hdr_count] = rb;
                    hdr_count++;
                    if (hdr_count == FIELD) begin
                        hdr_count = 0;
                        phase = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    length_bits[hdr_count] = rb;
                    hdr_count++;
                    if (hdr_count == FIELD) begin
                        hdr_count = 0;
                        phase = PH_DONE;
                        // method is judged only once the length is in
                        if (CFG_BITS'(method_bits) != method)
                            push(KIND_BADMETHOD, 8'h00, 1'b1);
                        else if (length_bits == '0)
                            push(KIND_EMPTY, 8'h00, 1'b1);
                        else if (length_bits[2:0] != 3'd0)
                            push(KIND_BADLEN, 8'h00, 1'b1);
                        else begin
                            phase     = PH_PAYLOAD;
                            bit_count = '0;
                            char_bits = '0;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    pos = bit_count[2:0];
                    char_bits[pos] = gb;
                    bit_count++;
                    if (pos == 3'd7) begin
                        if (bit_count == 32'(length_bits)) begin
                            phase = PH_DONE;
                            push(KIND_CHAR, char_bits, 1'b1);
                        end else begin
                            push(KIND_CHAR, char_bits, 1'b0);
                        end
                        char_bits = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [2:0] kind, logic [7:0] ch, logic last);
            report_t want;
            if (awaited_reports.size() == 0) begin
                $error("unexpected result: kind %0d char %02h last %0b", kind, ch, last);
                failures++;
                return;
            end
            want = awaited_reports.pop_front();
            if (want.kind == KIND_CHAR)
                chars_seen++;
            else
                status_seen++;
            if (kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, kind);
                failures++;
            end
            if (ch !== want.ch) begin
                $error("char_value: expected %02h, got %02h", want.ch, ch);
                failures++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, last);
                failures++;
            end
        endfunction
    endclass

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CFG_BITS-1:0] cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata     = '0;   // [7:0] red_value, [15:8] green_value
    logic                s_tuser     = 1'b0; // [0] start_of_image
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [7:0]          m_tdata;            // [7:0] char_value
    logic [2:0]          m_tuser;            // [2:0] kind
    logic                m_tlast;

    extract_scoreboard board;
    logic              steady    = 1'b0;
    int                cycles    = 0;
    int                hold_left = 0;
    int                pixels    = 0;
    int                images    = 0;
    int                settings  = 0;

    lsb_stego_extractor_core u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random back-pressure plus a couple of long hold-offs
    always @(posedge aclk) begin
        if (m_tvalid === 1'b1 && m_tready) begin
            board.check_result(m_tuser, m_tdata, m_tlast);
            // first hold lands inside a run of characters, so the core fills up
            if (board.chars_seen + board.status_seen == 8 ||
                board.chars_seen + board.status_seen == 24)
                hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic [7:0] rand_with_lsb(logic b);
        logic [7:0] v;
        v = 8'($urandom);
        v[0] = b;
        return v;
    endfunction

    task automatic send_pixel(input logic sof, input logic [7:0] red, input logic [7:0] green);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= sof;
        s_tdata  <= {green, red};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_pixel(sof, red[0], green[0]);
        pixels++;
    endtask

    // header bits ride on red LSBs, payload on green LSBs, the rest is random
    task automatic send_image(input logic sof, input logic [MAGIC_BITS-1:0] mark,
                              input logic [FIELD-1:0] meth, input logic [FIELD-1:0] len,
                              input int n_hdr, input int n_body, input fill_t fill,
                              input int n_tail);
        logic [HDR_BITS-1:0] hdr;
        logic                g;
        hdr = {len, meth, mark};
        images++;
        for (int i = 0; i < n_hdr; i++)
            send_pixel(sof && i == 0, rand_with_lsb(hdr[i]), 8'($urandom));
        for (int i = 0; i < n_body; i++) begin
            g = (fill == FILL_RANDOM) ? 1'($urandom) : (fill == FILL_ONES);
            send_pixel(1'b0, 8'($urandom), rand_with_lsb(g));
        end
        for (int i = 0; i < n_tail; i++)
            send_pixel(1'b0, 8'($urandom), 8'($urandom));
    endtask

    task automatic set_method(input logic [CFG_BITS-1:0] value);
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        board.method = value;
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [CFG_BITS-1:0]   meth;
        logic [FIELD-1:0]      len;
        logic [MAGIC_BITS-1:0] mark;
        int                    pick;
        int                    nchars;
        int                    n_rand;
        board = new();
        board.clear();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first image carries no start flag after reset
        send_image(1'b0, MAGIC_WORD, 0, 8, HDR_BITS, 8, FILL_ZEROS, 3);
        send_image(1'b1, MAGIC_WORD, 0, 0, HDR_BITS, 0, FILL_RANDOM, 2);
        send_image(1'b1, MAGIC_WORD, 0, 12, HDR_BITS, 0, FILL_RANDOM, 2);
        send_image(1'b1, MAGIC_WORD, 32'h8000_0000, 8, HDR_BITS, 0, FILL_RANDOM, 0);
        // mark wrong in its top bit only; the trailing pixels are ignored
        send_image(1'b1, MAGIC_WORD ^ 48'h8000_0000_0000, 0, 8, HDR_BITS, 8, FILL_ONES, 4);
        // restart in the middle of the header
        send_image(1'b1, MAGIC_WORD, 0, 8, 30, 0, FILL_RANDOM, 0);
        set_method(32'hFFFF_FFFF);
        send_image(1'b1, MAGIC_WORD, 32'hFFFF_FFFF, 16, HDR_BITS, 16, FILL_ONES, 0);
        // largest length that is a multiple of eight; cut short by the next image
        send_image(1'b1, MAGIC_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFF8, HDR_BITS, 24, FILL_RANDOM, 0);
        send_image(1'b1, MAGIC_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, HDR_BITS, 0, FILL_RANDOM, 1);

        n_rand = 0;
        while (pixels < 1950) begin
            if (n_rand % 5 == 0) begin
                pick = $urandom_range(3);
                set_method(pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF :
                           pick == 2 ? 32'(1) << $urandom_range(31) : $urandom);
            end
            steady = (n_rand >= 1 && n_rand < 4);
            meth   = board.method;
            nchars = $urandom_range(1, 12);
            len    = 8 * nchars;
            pick   = $urandom_range(99);
            if (pick < 60) begin
                send_image(1'b1, MAGIC_WORD, meth, len, HDR_BITS,
                           $urandom_range(9) == 0 ? $urandom_range(len - 1) : len,
                           FILL_RANDOM, $urandom_range(4));
            end else if (pick < 68) begin
                meth = ($urandom_range(1) == 0) ? meth ^ (32'(1) << $urandom_range(31))
                                                : meth ^ 32'($urandom | 1);
                send_image(1'b1, MAGIC_WORD, meth, len, HDR_BITS, 0, FILL_RANDOM, 2);
            end else if (pick < 74) begin
                len = $urandom;
                if (len[2:0] == 3'd0)
                    len[$urandom_range(2)] = 1'b1;
                send_image(1'b1, MAGIC_WORD, meth, len, HDR_BITS, 0, FILL_RANDOM, 2);
            end else if (pick < 79) begin
                send_image(1'b1, MAGIC_WORD, meth, 0, HDR_BITS, 0, FILL_RANDOM, 2);
            end else if (pick < 87) begin
                mark = MAGIC_WORD ^ (48'(1) << $urandom_range(MAGIC_BITS - 1));
                if ($urandom_range(1) == 0)
                    mark = MAGIC_BITS'({$urandom, $urandom});
                send_image(1'b1, mark, meth, len, $urandom_range(MAGIC_BITS, HDR_BITS),
                           0, FILL_RANDOM, 0);
            end else if (pick < 93) begin
                send_image(1'b1, MAGIC_WORD, meth, len, $urandom_range(1, HDR_BITS - 1),
                           0, FILL_RANDOM, 0);
            end else begin
                // noise, the odd one carrying a start flag
                repeat ($urandom_range(1, 30))
                    send_pixel($urandom_range(9) == 0, 8'($urandom), 8'($urandom));
            end
            n_rand++;
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Covered %0d pixels in %0d images under %0d method settings;",
                 pixels, images, settings);
        $display("checked %0d characters and %0d status reports.",
                 board.chars_seen, board.status_seen);
        if (board.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
